// ===== design/bqa_pkg.sv =====
// ----------------------------------------------------------------------------
// bqa_pkg
// Types and constants shared by the bitmap quantum allocator modules.
// ----------------------------------------------------------------------------
package bqa_pkg;

    localparam int BW = 8;   // bound and position width, holds 0..255
    localparam int NW = 17;  // quantum count width, holds up to 131071

    typedef logic [BW-1:0] t_bnd;
    typedef logic [NW-1:0] t_cnt;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_GROW  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        STS_ALLOC   = 3'd0,
        STS_FREED   = 3'd1,
        STS_INPLACE = 3'd2,
        STS_SAME    = 3'd3,
        STS_MOVED   = 3'd4,
        STS_NOROOM  = 3'd5,
        STS_BIG     = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_PICK,
        ST_MODIFY,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        MAP_HOLD,
        MAP_CLEAR,
        MAP_SCAN,
        MAP_MODIFY
    } t_map_op;

    typedef struct packed {
        t_map_op op;
        t_bnd    n;      // run length searched during scan
        t_bnd    w_lo;   // in-place window checked during scan
        t_bnd    w_hi;
        t_bnd    s_lo;   // range set during modify
        t_bnd    s_hi;
        t_bnd    c_lo;   // range cleared during modify, wins over set
        t_bnd    c_hi;
    } t_map_ctl;

    typedef struct packed {
        logic found;
        t_bnd at;
        logic conflict;
        logic last;
    } t_map_sts;

endpackage

// ===== design/bqa_quanta.sv =====
// ----------------------------------------------------------------------------
// bqa_quanta
// Converts a byte size to a quantum count: 0 or 1 byte is one quantum,
// otherwise the size rounded up to whole quanta.
// ----------------------------------------------------------------------------
module bqa_quanta #(
    parameter int QUANTUM_SHIFT = 8
) (
    input  logic [15:0]       i_bytes,
    output bqa_pkg::t_cnt     o_count
);
    import bqa_pkg::*;

    localparam t_cnt RND = t_cnt'((t_cnt'(1) << QUANTUM_SHIFT) - t_cnt'(1));

    t_cnt sum;

    assign sum     = t_cnt'(i_bytes) + RND;
    assign o_count = (i_bytes <= 16'd1) ? t_cnt'(1) : (sum >> QUANTUM_SHIFT);

endmodule

// ===== design/bqa_map.sv =====
// ----------------------------------------------------------------------------
// bqa_map
// Used bitmap held in a rotating shift register. In a scan or modify pass
// one quantum passes the head each cycle: a scan pass finds the lowest
// free run and checks the in-place window, a modify pass sets/clears ranges.
// ----------------------------------------------------------------------------
module bqa_map #(
    parameter int QUANTA = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bqa_pkg::t_map_ctl  i_ctl,
    output bqa_pkg::t_map_sts  o_sts,
    output logic [QUANTA-1:0]  o_map
);
    import bqa_pkg::*;

    localparam int PW = (QUANTA > 1) ? $clog2(QUANTA) : 1;

    logic [QUANTA-1:0] r_map, n_map;
    logic [PW-1:0]     r_pos, n_pos;
    t_bnd              r_run, n_run;
    logic              r_found, n_found;
    t_bnd              r_at, n_at;
    logic              r_conf, n_conf;

    t_bnd pz;
    logic head;
    logic last;
    logic in_set, in_clr, in_win;

    assign pz     = t_bnd'(r_pos);
    assign head   = r_map[0];
    assign last   = (r_pos == PW'(QUANTA - 1));
    assign in_set = (pz >= i_ctl.s_lo) && (pz < i_ctl.s_hi);
    assign in_clr = (pz >= i_ctl.c_lo) && (pz < i_ctl.c_hi);
    assign in_win = (pz >= i_ctl.w_lo) && (pz < i_ctl.w_hi);

    always_comb begin
        n_map   = r_map;
        n_pos   = r_pos;
        n_run   = r_run;
        n_found = r_found;
        n_at    = r_at;
        n_conf  = r_conf;
        unique case (i_ctl.op)
            MAP_CLEAR: begin
                n_pos   = '0;
                n_run   = '0;
                n_found = 1'b0;
                n_at    = '0;
                n_conf  = 1'b0;
            end
            MAP_SCAN: begin
                n_map = {head, r_map[QUANTA-1:1]};
                n_pos = last ? '0 : r_pos + PW'(1);
                n_run = head ? '0 : r_run + t_bnd'(1);
                if (!r_found && !head && (n_run == i_ctl.n)) begin
                    n_found = 1'b1;
                    n_at    = pz + t_bnd'(1) - i_ctl.n;
                end
                if (head && in_win) begin
                    n_conf = 1'b1;
                end
            end
            MAP_MODIFY: begin
                n_map = {(head | in_set) & ~in_clr, r_map[QUANTA-1:1]};
                n_pos = last ? '0 : r_pos + PW'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map   <= '0;
            r_pos   <= '0;
            r_run   <= '0;
            r_found <= 1'b0;
            r_at    <= '0;
            r_conf  <= 1'b0;
        end else begin
            r_map   <= n_map;
            r_pos   <= n_pos;
            r_run   <= n_run;
            r_found <= n_found;
            r_at    <= n_at;
            r_conf  <= n_conf;
        end
    end

    assign o_sts.found    = r_found;
    assign o_sts.at       = r_at;
    assign o_sts.conflict = r_conf;
    assign o_sts.last     = last;
    assign o_map          = r_map;

`ifndef ASSERT_OFF
    // scan only rotates, never alters a bit
    a_scan_keeps_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.op == MAP_SCAN) |=> (r_map == {$past(r_map[0]), $past(r_map[QUANTA-1:1])}))
        else $error("map changed during scan");
`endif

endmodule

// ===== design/bqa_ctrl.sv =====
// ----------------------------------------------------------------------------
// bqa_ctrl
// Command sequencer: decodes an item, runs scan and modify passes over the
// bitmap and picks the outcome.
// ----------------------------------------------------------------------------
module bqa_ctrl #(
    parameter int QUANTA = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_cmd,
    input  logic [5:0]         i_region_offset,
    input  bqa_pkg::t_cnt      i_n_new,
    input  bqa_pkg::t_cnt      i_n_old,
    input  bqa_pkg::t_map_sts  i_sts,
    output bqa_pkg::t_map_ctl  o_ctl,
    input  logic               i_out_free,
    output logic               o_fin,
    output bqa_pkg::t_status   o_status,
    output logic [5:0]         o_offset
);
    import bqa_pkg::*;

    localparam t_cnt QMAX = t_cnt'(QUANTA);
    localparam t_bnd QB   = t_bnd'(QUANTA);

    t_state  r_state, n_state;
    t_cmd    r_cmd;
    logic [5:0] r_off;
    t_cnt    r_n_new, r_n_old;
    t_bnd    r_w_lo, r_w_hi, r_s_lo, r_s_hi, r_c_lo, r_c_hi;
    logic    r_fit;
    t_status r_status;
    logic [5:0] r_res;

    t_bnd  nn8, no8, off8, nsat8, top_new, top_old;
    logic  big, not_larger, fit, inplace;
    t_state dec_next, pick_next;

    assign nn8        = r_n_new[BW-1:0];
    assign no8        = r_n_old[BW-1:0];
    assign off8       = t_bnd'(r_off);
    assign big        = (r_n_new > QMAX);
    assign not_larger = (r_n_new <= r_n_old);
    assign nsat8      = big ? QB : nn8;
    assign top_new    = off8 + nn8;
    assign top_old    = off8 + no8;
    assign fit        = (top_new <= QB);
    assign inplace    = r_fit && !i_sts.conflict;

    always_comb begin
        unique case (r_cmd)
            CMD_ALLOC: dec_next = big ? ST_DONE : ST_SCAN;
            CMD_FREE:  dec_next = ST_MODIFY;
            CMD_GROW:  dec_next = (not_larger || big) ? ST_DONE : ST_SCAN;
            default:   dec_next = ST_DONE;
        endcase
    end

    always_comb begin
        if (r_cmd == CMD_GROW && inplace) begin
            pick_next = ST_MODIFY;
        end else begin
            pick_next = i_sts.found ? ST_MODIFY : ST_DONE;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_DECODE;
            ST_DECODE: n_state = dec_next;
            ST_SCAN:   if (i_sts.last) n_state = ST_PICK;
            ST_PICK:   n_state = pick_next;
            ST_MODIFY: if (i_sts.last) n_state = ST_DONE;
            ST_DONE:   if (i_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_fin      = 1'b0;
        o_ctl.op   = MAP_HOLD;
        o_ctl.n    = nn8;
        o_ctl.w_lo = r_w_lo;
        o_ctl.w_hi = r_w_hi;
        o_ctl.s_lo = r_s_lo;
        o_ctl.s_hi = r_s_hi;
        o_ctl.c_lo = r_c_lo;
        o_ctl.c_hi = r_c_hi;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_ctl.op = MAP_CLEAR;
            end
            ST_SCAN:   o_ctl.op = MAP_SCAN;
            ST_MODIFY: o_ctl.op = MAP_MODIFY;
            ST_DONE:   o_fin = i_out_free;
            default: begin
            end
        endcase
    end

    assign o_status   = r_status;
    assign o_offset   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    r_cmd   <= t_cmd'(i_cmd);
                    r_off   <= i_region_offset;
                    r_n_new <= i_n_new;
                    r_n_old <= i_n_old;
                end
            end
            ST_DECODE: begin
                r_s_lo   <= '0;
                r_s_hi   <= '0;
                r_c_lo   <= '0;
                r_c_hi   <= '0;
                r_w_lo   <= top_old;
                r_w_hi   <= fit ? top_new : top_old;
                r_fit    <= fit;
                r_res    <= '0;
                r_status <= STS_SAME;
                unique case (r_cmd)
                    CMD_ALLOC: begin
                        if (big) r_status <= STS_BIG;
                    end
                    CMD_FREE: begin
                        r_c_lo   <= off8;
                        r_c_hi   <= off8 + nsat8;
                        r_status <= STS_FREED;
                    end
                    CMD_GROW: begin
                        if (not_larger) begin
                            r_res <= r_off;
                        end else if (big) begin
                            r_status <= STS_BIG;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_PICK: begin
                if (r_cmd == CMD_GROW && inplace) begin
                    r_s_lo   <= r_w_lo;
                    r_s_hi   <= r_w_hi;
                    r_status <= STS_INPLACE;
                    r_res    <= r_off;
                end else if (i_sts.found) begin
                    r_s_lo   <= i_sts.at;
                    r_s_hi   <= i_sts.at + nn8;
                    r_res    <= i_sts.at[5:0];
                    if (r_cmd == CMD_GROW) begin
                        r_c_lo   <= off8;
                        r_c_hi   <= top_old;
                        r_status <= STS_MOVED;
                    end else begin
                        r_status <= STS_ALLOC;
                    end
                end else begin
                    r_status <= STS_NOROOM;
                end
            end
            default: begin
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_decode_after_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DECODE) |-> ($past(r_state) == ST_IDLE))
        else $error("decode entered without an accepted item");
`endif
`ifndef ASSERT_OFF
    a_pass_full_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_MODIFY || r_state == ST_SCAN) && n_state != r_state)
        |-> i_sts.last)
        else $error("bitmap pass ended before a full rotation");
`endif

endmodule

// ===== design/bitmap_quantum_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_quantum_allocator
// Flow: free runs one modify pass; alloc and grow that scan run a scan pass,
//   then a modify pass unless there is no room; other commands go straight to the result.
// Throughput: one item at a time; the next item is accepted the cycle after
//   the result is registered. During scan and modify passes the bitmap rotates one quantum per cycle.
// Reset: synchronous, active low; clears the bitmap (all quanta free).
// ----------------------------------------------------------------------------
module bitmap_quantum_allocator #(
    parameter int QUANTA        = 64,
    parameter int QUANTUM_SHIFT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_cmd,
    input  logic [5:0]  i_region_offset,
    input  logic [15:0] i_size_bytes,
    input  logic [15:0] i_old_size_bytes,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [5:0]  o_result_offset,
    output logic [63:0] o_used_map
);
    import bqa_pkg::*;

    t_cnt              n_new, n_old;
    t_map_ctl          map_ctl;
    t_map_sts          map_sts;
    logic [QUANTA-1:0] map;
    logic              out_free, fin;
    t_status           status;
    logic [5:0]        offset;

    logic        r_out_valid;
    logic [2:0]  r_status;
    logic [5:0]  r_offset;
    logic [63:0] r_used_map;

    bqa_quanta #(.QUANTUM_SHIFT(QUANTUM_SHIFT)) u_q_new (
        .i_bytes (i_size_bytes),
        .o_count (n_new)
    );

    bqa_quanta #(.QUANTUM_SHIFT(QUANTUM_SHIFT)) u_q_old (
        .i_bytes (i_old_size_bytes),
        .o_count (n_old)
    );

    bqa_map #(.QUANTA(QUANTA)) u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (map_ctl),
        .o_sts   (map_sts),
        .o_map   (map)
    );

    bqa_ctrl #(.QUANTA(QUANTA)) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (i_cmd),
        .i_region_offset (i_region_offset),
        .i_n_new         (n_new),
        .i_n_old         (n_old),
        .i_sts           (map_sts),
        .o_ctl           (map_ctl),
        .i_out_free      (out_free),
        .o_fin           (fin),
        .o_status        (status),
        .o_offset        (offset)
    );

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_status   <= 3'(status);
            r_offset   <= offset;
            r_used_map <= 64'(map);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_result_offset = r_offset;
    assign o_used_map      = r_used_map;

`ifndef ASSERT_OFF
    a_map_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_used_map >> QUANTA) == 64'd0))
        else $error("used map has bits past the pool");
`endif
`ifndef ASSERT_OFF
    a_busy_while_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin |=> r_out_valid)
        else $error("result not registered after completion");
`endif

endmodule
